[design/integer_to_radix_ascii_assert.svh]
// Assertion macros shared by the integer to radix text converter.
`ifndef INTEGER_TO_RADIX_ASCII_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ITRA_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define ITRA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Checks that a condition holds at every clock edge out of reset.
`define ITRA_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

[design/itra_pkg.sv]
// Package with types, constants, microcode and helper functions of the converter.
package itra_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W = 8;
    localparam int STEP_W = 3;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd62;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_LOWER = 6'd36;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE = 3'd0;
    localparam step_t STEP_DIV_GO = 3'd1;
    localparam step_t STEP_DIV_WAIT = 3'd2;
    localparam step_t STEP_TEST = 3'd3;
    localparam step_t STEP_SIGN_TEST = 3'd4;
    localparam step_t STEP_SIGN = 3'd5;
    localparam step_t STEP_READ = 3'd6;
    localparam step_t STEP_EMIT = 3'd7;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_GO,
        OP_DIV_STORE,
        OP_EMIT_SIGN,
        OP_READ,
        OP_EMIT_DIGIT
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_DIV_DONE,
        COND_MAG_ZERO,
        COND_NEG,
        COND_OUT_FREE,
        COND_CNT_NONZERO
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jump_true;
        step_t jump_false;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic div_done;
        logic mag_zero;
        logic neg;
        logic out_free;
        logic cnt_nonzero;
    } flags_t;

    typedef struct packed {
        op_t   op;
        step_t step;
    } ctrl_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        unique case (step)
            STEP_IDLE:      w = '{OP_LOAD, COND_IN_VALID, STEP_DIV_GO, STEP_IDLE};
            STEP_DIV_GO:    w = '{OP_DIV_GO, COND_ALWAYS, STEP_DIV_WAIT, STEP_DIV_WAIT};
            STEP_DIV_WAIT:  w = '{OP_DIV_STORE, COND_DIV_DONE, STEP_TEST, STEP_DIV_WAIT};
            STEP_TEST:      w = '{OP_NOP, COND_MAG_ZERO, STEP_SIGN_TEST, STEP_DIV_GO};
            STEP_SIGN_TEST: w = '{OP_NOP, COND_NEG, STEP_SIGN, STEP_READ};
            STEP_SIGN:      w = '{OP_EMIT_SIGN, COND_OUT_FREE, STEP_READ, STEP_SIGN};
            STEP_READ:      w = '{OP_READ, COND_CNT_NONZERO, STEP_EMIT, STEP_IDLE};
            STEP_EMIT:      w = '{OP_EMIT_DIGIT, COND_OUT_FREE, STEP_READ, STEP_EMIT};
            default:        w = '{OP_NOP, COND_ALWAYS, STEP_IDLE, STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [RADIX_W-1:0] radix_clamp(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] c;
        if (r < RADIX_MIN)
        begin
            c = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            c = RADIX_MAX;
        end
        else
        begin
            c = r;
        end
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DIGIT_LOWER)
        begin
            c = CHAR_LOWER_A + {2'b00, d - DIGIT_LOWER};
        end
        else if (d >= DIGIT_TEN)
        begin
            c = CHAR_UPPER_A + {2'b00, d - DIGIT_TEN};
        end
        else
        begin
            c = CHAR_ZERO + {2'b00, d};
        end
        return c;
    endfunction

endpackage

[design/itra_seq.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module itra_seq
(
    input  logic             clk,
    input  logic             rst_n,
    input  itra_pkg::flags_t flags,
    output itra_pkg::ctrl_t  ctrl
);

    itra_pkg::step_t  step_reg;
    itra_pkg::step_t  step_next;
    itra_pkg::ucode_t uword;
    logic             cond_true;

    always_comb
    begin
        uword = itra_pkg::ucode_rom(step_reg);
        unique case (uword.cond)
            itra_pkg::COND_ALWAYS:      cond_true = 1'b1;
            itra_pkg::COND_IN_VALID:    cond_true = flags.in_valid;
            itra_pkg::COND_DIV_DONE:    cond_true = flags.div_done;
            itra_pkg::COND_MAG_ZERO:    cond_true = flags.mag_zero;
            itra_pkg::COND_NEG:         cond_true = flags.neg;
            itra_pkg::COND_OUT_FREE:    cond_true = flags.out_free;
            itra_pkg::COND_CNT_NONZERO: cond_true = flags.cnt_nonzero;
            default:                    cond_true = 1'b0;
        endcase
        step_next = cond_true ? uword.jump_true : uword.jump_false;
    end

    always_comb
    begin
        ctrl.op   = cond_true ? uword.op : itra_pkg::OP_NOP;
        ctrl.step = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= itra_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

[design/itra_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module itra_div
#(
    parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [VALUE_WIDTH-1:0]       dividend,
    input  logic [itra_pkg::RADIX_W-1:0] divisor,
    output logic [VALUE_WIDTH-1:0]       quotient,
    output logic [itra_pkg::DIGIT_W-1:0] remainder,
    output logic                         done
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                         busy_reg;
    logic                         busy_next;
    logic                         done_reg;
    logic                         done_next;
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             cnt_next;
    logic [itra_pkg::DIGIT_W-1:0] rem_reg;
    logic [itra_pkg::DIGIT_W-1:0] rem_next;
    logic [VALUE_WIDTH-1:0]       quo_reg;
    logic [VALUE_WIDTH-1:0]       quo_next;
    logic [itra_pkg::DIGIT_W:0]   shifted;
    logic [itra_pkg::DIGIT_W:0]   trial;
    logic                         fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        fits      = shifted >= {1'b0, divisor};
        trial     = shifted - {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};
            rem_next = fits ? trial[itra_pkg::DIGIT_W-1:0] : shifted[itra_pkg::DIGIT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

[design/itra_dstore.sv]
// Digit store: one write port and one registered read port.
module itra_dstore
#(
    parameter int DEPTH = itra_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [itra_pkg::DIGIT_W-1:0] wdata,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [itra_pkg::DIGIT_W-1:0] rdata
);

    logic [itra_pkg::DIGIT_W-1:0] mem [DEPTH];
    logic [itra_pkg::DIGIT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/integer_to_radix_ascii.sv]
// Integer to radix text converter: top level with datapath registers and output stage.
//
// A signed integer arrives on the s_axis channel; its text in the base held in
// the radix register leaves on the m_axis channel, one ASCII character per
// transfer, most significant digit first, with a leading minus for negatives.
// tlast marks the final character of each value. The user must write the radix over
// the cfg channel only while the block is idle; the block itself does not enforce it.
// Codes below 2 act as 2, above 62 as 62. A microcoded sequencer runs a restoring
// divider that yields one quotient bit per cycle for each digit and stores each
// remainder as a digit; the digits are then read back and emitted, after the minus
// sign for negatives. The next item is accepted once the sequencer has returned to
// idle via its read step after the last character is placed in the output
// register, while that character may still wait there.
// A stalled receiver holds the output register and the sequencer waits.
// Reset empties the output register, returns to idle and sets the radix to 10.
module integer_to_radix_ascii
#(
    parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: value.
    input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: character.
    output logic [itra_pkg::CHAR_W-1:0]          m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [itra_pkg::RADIX_W-1:0]         cfg_data
);

    `include "integer_to_radix_ascii_assert.svh"

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int AW = $clog2(VALUE_WIDTH);

    itra_pkg::flags_t             flags;
    itra_pkg::ctrl_t              ctrl;
    logic [itra_pkg::RADIX_W-1:0] radix_reg;
    logic [VALUE_WIDTH-1:0]       mag_reg;
    logic [VALUE_WIDTH-1:0]       mag_next;
    logic                         neg_reg;
    logic                         neg_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [CNT_W-1:0]             count_dec;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [itra_pkg::CHAR_W-1:0]  out_char_reg;
    logic [itra_pkg::CHAR_W-1:0]  out_char_next;
    logic                         out_last_reg;
    logic                         out_last_next;
    logic [VALUE_WIDTH-1:0]       in_value;
    logic [VALUE_WIDTH-1:0]       quotient;
    logic [itra_pkg::DIGIT_W-1:0] remainder;
    logic [itra_pkg::DIGIT_W-1:0] rd_digit;
    logic                         div_done;
    logic                         store_we;

    assign in_value  = s_axis_tdata[VALUE_WIDTH-1:0];
    assign count_dec = count_reg - 1'b1;
    assign store_we  = (ctrl.op == itra_pkg::OP_DIV_STORE) && (count_reg < CNT_W'(VALUE_WIDTH));

    always_comb
    begin
        flags.in_valid    = s_axis_tvalid;
        flags.div_done    = div_done;
        flags.mag_zero    = mag_reg == '0;
        flags.neg         = neg_reg;
        flags.out_free    = !out_valid_reg || m_axis_tready;
        flags.cnt_nonzero = count_reg != '0;
    end

    itra_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    itra_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.op == itra_pkg::OP_DIV_GO),
        .dividend  (mag_reg),
        .divisor   (itra_pkg::radix_clamp(radix_reg)),
        .quotient  (quotient),
        .remainder (remainder),
        .done      (div_done)
    );

    itra_dstore #(
        .DEPTH (VALUE_WIDTH)
    ) u_dstore
    (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (remainder),
        .re    (ctrl.op == itra_pkg::OP_READ),
        .raddr (count_dec[AW-1:0]),
        .rdata (rd_digit)
    );

    always_comb
    begin
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        unique case (ctrl.op)
            itra_pkg::OP_LOAD:
            begin
                neg_next   = in_value[VALUE_WIDTH-1];
                mag_next   = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
                count_next = '0;
            end
            itra_pkg::OP_DIV_STORE:
            begin
                mag_next = quotient;
                if (store_we)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            itra_pkg::OP_READ:
            begin
                count_next = count_dec;
            end
            itra_pkg::OP_EMIT_SIGN:
            begin
                out_valid_next = 1'b1;
                out_char_next  = itra_pkg::CHAR_MINUS;
                out_last_next  = 1'b0;
            end
            itra_pkg::OP_EMIT_DIGIT:
            begin
                out_valid_next = 1'b1;
                out_char_next  = itra_pkg::digit_char(rd_digit);
                out_last_next  = count_reg == '0;
            end
            default:
            begin
                mag_next = mag_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= itra_pkg::RADIX_RESET;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            mag_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                radix_reg <= cfg_data;
            end
            neg_reg       <= neg_next;
            count_reg     <= count_next;
            mag_reg       <= mag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign s_axis_tready = ctrl.step == itra_pkg::STEP_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;
    assign cfg_ready     = 1'b1;

    `ITRA_ASSERT_NEXT(a_load_clears_count, s_axis_tvalid && s_axis_tready, count_reg == '0)
    `ITRA_ASSERT_ALWAYS(a_count_in_range, count_reg <= CNT_W'(VALUE_WIDTH))
    `ITRA_ASSERT_IMPLIES(a_div_done_when_waiting, div_done,
        ctrl.step == itra_pkg::STEP_DIV_WAIT)
    `ITRA_ASSERT_IMPLIES(a_emit_only_when_free,
        ctrl.op == itra_pkg::OP_EMIT_DIGIT || ctrl.op == itra_pkg::OP_EMIT_SIGN,
        !m_axis_tvalid || m_axis_tready)

endmodule
